// ===== rtl/itra_pkg.sv =====
package itra_pkg;

  localparam int STEP_BITS = 8;
  localparam int DIGIT_W   = 4;
  localparam int RADIX_W   = 5;
  localparam int CHAR_W    = 8;

  localparam logic [CHAR_W-1:0]  CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0]  CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0]  CH_A      = 8'h41;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  typedef enum logic {
    KIND_ZERO,
    KIND_CONV
  } itra_kind_t;

  typedef struct packed {
    itra_kind_t         kind;
    logic               neg;
    logic [RADIX_W-1:0] radix;
  } itra_ctl_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ZERO,
    B_DIV,
    B_SIGN,
    B_POP,
    B_OUT
  } itra_bstate_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

// ===== rtl/itra_ram.sv =====
module itra_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/itra_front.sv =====
module itra_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((VALUE_BITS+itra_pkg::RADIX_W+7)/8)*8-1:0] in_tdata,
  input  logic                                    in_tuser,
  output logic                                    q_valid,
  input  logic                                    q_ready,
  output itra_pkg::itra_ctl_t                     q_ctl,
  output logic [VALUE_BITS-1:0]                   q_mag
);

  logic [VALUE_BITS-1:0]        value;
  logic [itra_pkg::RADIX_W-1:0] radix;
  logic                         neg;
  logic                         drop;
  logic                         bad;
  logic [VALUE_BITS-1:0]        mag;
  itra_pkg::itra_ctl_t          ctl;
  logic                         push;
  logic                         pop;

  itra_pkg::itra_ctl_t   ctl_r [2];
  logic [VALUE_BITS-1:0] mag_r [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            cnt_r, cnt_nxt;

  always_comb begin
    value     = in_tdata[VALUE_BITS-1:0];
    radix     = in_tdata[VALUE_BITS +: itra_pkg::RADIX_W];
    neg       = in_tuser & value[VALUE_BITS-1];
    drop      = in_tuser & (radix > itra_pkg::RADIX_MAX);
    bad       = (radix < itra_pkg::RADIX_MIN) | (radix > itra_pkg::RADIX_MAX);
    mag       = neg ? (~value + 1'b1) : value;
    ctl.radix = radix;
    ctl.neg   = neg & ~bad;
    ctl.kind  = (bad || mag == '0) ? itra_pkg::KIND_ZERO : itra_pkg::KIND_CONV;
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid & in_tready & ~drop;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid & q_ready;
  assign q_ctl     = ctl_r[rd_ptr_r];
  assign q_mag     = mag_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_r[wr_ptr_r] <= ctl;
      mag_r[wr_ptr_r] <= mag;
    end
  end

endmodule

// ===== rtl/itra_back.sv =====
module itra_back #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  itra_pkg::itra_ctl_t                 q_ctl,
  input  logic [VALUE_BITS-1:0]               q_mag,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [itra_pkg::CHAR_W-1:0]         out_tdata,
  output logic                                out_tlast
);

  localparam int PASSES = (VALUE_BITS + itra_pkg::STEP_BITS - 1) / itra_pkg::STEP_BITS;
  localparam int WORK_W = PASSES * itra_pkg::STEP_BITS;
  localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int AW     = $clog2(MAX_DIGITS);

  itra_pkg::itra_bstate_t state_r, state_nxt;
  logic [WORK_W-1:0]               q_r, q_nxt;
  logic [itra_pkg::DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [itra_pkg::RADIX_W-1:0]    radix_r, radix_nxt;
  logic                            sign_r, sign_nxt;
  logic [PASS_W-1:0]               pass_r, pass_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [itra_pkg::CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            out_free;
  logic                            load_out;
  logic [WORK_W-1:0]               div_q;
  logic [itra_pkg::DIGIT_W-1:0]    div_rem;
  logic                            ram_wr_en;
  logic                            ram_rd_en;
  logic [CNT_W-1:0]                cnt_m1;
  logic [itra_pkg::DIGIT_W-1:0]    ram_rd_data;

  itra_ram #(
    .WIDTH(itra_pkg::DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_stack (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(cnt_r[AW-1:0]),
    .wr_data(div_rem),
    .rd_en  (ram_rd_en),
    .rd_addr(cnt_m1[AW-1:0]),
    .rd_data(ram_rd_data)
  );

  // Restoring division of the working word by the base, one byte of the dividend per cycle.
  always_comb begin
    logic [itra_pkg::DIGIT_W-1:0]   r;
    logic [itra_pkg::DIGIT_W:0]     t;
    logic [itra_pkg::STEP_BITS-1:0] top;
    logic [itra_pkg::STEP_BITS-1:0] qb;
    r   = rem_r;
    top = q_r[WORK_W-1 -: itra_pkg::STEP_BITS];
    qb  = '0;
    for (int i = itra_pkg::STEP_BITS - 1; i >= 0; i--) begin
      t = {r, top[i]};
      if (t >= radix_r) begin
        r     = itra_pkg::DIGIT_W'(t - radix_r);
        qb[i] = 1'b1;
      end else begin
        r     = t[itra_pkg::DIGIT_W-1:0];
        qb[i] = 1'b0;
      end
    end
    div_rem = r;
    div_q   = (q_r << itra_pkg::STEP_BITS) | WORK_W'(qb);
  end

  assign out_free = ~out_valid_r | out_tready;
  assign cnt_m1   = cnt_r - 1'b1;

  always_comb begin
    state_nxt    = state_r;
    q_nxt        = q_r;
    rem_nxt      = rem_r;
    radix_nxt    = radix_r;
    sign_nxt     = sign_r;
    pass_nxt     = pass_r;
    cnt_nxt      = cnt_r;
    q_ready      = 1'b0;
    load_out     = 1'b0;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    ram_wr_en    = 1'b0;
    ram_rd_en    = 1'b0;
    case (state_r)
      itra_pkg::B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          q_nxt     = WORK_W'(q_mag);
          rem_nxt   = '0;
          radix_nxt = q_ctl.radix;
          sign_nxt  = q_ctl.neg;
          pass_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = (q_ctl.kind == itra_pkg::KIND_ZERO) ? itra_pkg::B_ZERO : itra_pkg::B_DIV;
        end
      end
      itra_pkg::B_ZERO: begin
        if (out_free) begin
          load_out     = 1'b1;
          out_char_nxt = itra_pkg::CH_ZERO;
          out_last_nxt = 1'b1;
          state_nxt    = itra_pkg::B_IDLE;
        end
      end
      itra_pkg::B_DIV: begin
        q_nxt = div_q;
        if (pass_r == PASS_W'(PASSES - 1)) begin
          pass_nxt = '0;
          rem_nxt  = '0;
          if (cnt_r < CNT_W'(MAX_DIGITS)) begin
            ram_wr_en = 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
          end
          if (div_q == '0) begin
            state_nxt = sign_r ? itra_pkg::B_SIGN : itra_pkg::B_POP;
          end
        end else begin
          pass_nxt = pass_r + 1'b1;
          rem_nxt  = div_rem;
        end
      end
      itra_pkg::B_SIGN: begin
        if (out_free) begin
          load_out     = 1'b1;
          out_char_nxt = itra_pkg::CH_MINUS;
          out_last_nxt = 1'b0;
          state_nxt    = itra_pkg::B_POP;
        end
      end
      itra_pkg::B_POP: begin
        ram_rd_en = 1'b1;
        cnt_nxt   = cnt_m1;
        state_nxt = itra_pkg::B_OUT;
      end
      itra_pkg::B_OUT: begin
        if (out_free) begin
          load_out     = 1'b1;
          out_char_nxt = itra_pkg::digit_char(ram_rd_data);
          out_last_nxt = (cnt_r == '0);
          state_nxt    = (cnt_r == '0) ? itra_pkg::B_IDLE : itra_pkg::B_POP;
        end
      end
      default: begin
        state_nxt = itra_pkg::B_IDLE;
      end
    endcase
    out_valid_nxt = load_out | (out_valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itra_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      pass_r      <= '0;
      sign_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      sign_r      <= sign_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    radix_r    <= radix_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/integer_to_radix_ascii.sv =====
// Channel | Direction | Beat contents
// in_     | slave     | tdata: value, radix, zero pad; tuser: func
// out_    | master    | tdata: char_code; tlast: last
//
// The front takes one beat per cycle into a two-entry queue while the queue has room;
// a signed beat whose base is above 16 is taken but dropped, giving no output.
// The divider makes each digit in one pass over the working word, eight bits a cycle.
// A zero value or any other bad base gives a lone '0'; signed negatives lead with '-'.
// Reset is synchronous; the digit stack needs no clearing.
// A stall on the output holds the back end, and the queue keeps taking input until full.
module integer_to_radix_ascii #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // Fields from bit 0: value, radix, zero pad to whole bytes.
  input  logic [((VALUE_BITS+itra_pkg::RADIX_W+7)/8)*8-1:0] in_tdata,
  // Fields from bit 0: func.
  input  logic                                    in_tuser,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // Fields from bit 0: char_code.
  output logic [itra_pkg::CHAR_W-1:0]             out_tdata,
  output logic                                    out_tlast
);

  logic                  q_valid;
  logic                  q_ready;
  itra_pkg::itra_ctl_t   q_ctl;
  logic [VALUE_BITS-1:0] q_mag;

  itra_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_ctl    (q_ctl),
    .q_mag    (q_mag)
  );

  itra_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_ctl     (q_ctl),
    .q_mag     (q_mag),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

// ===== rtl/itra_checker.sv =====
module itra_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [itra_pkg::CHAR_W-1:0] out_tdata,
  input logic                        out_tlast
);

  logic char_ok;

  assign char_ok = (out_tdata >= itra_pkg::CH_ZERO && out_tdata <= 8'h39) ||
                   (out_tdata >= itra_pkg::CH_A && out_tdata <= 8'h46) ||
                   (out_tdata == itra_pkg::CH_MINUS);

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("Block not empty after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("Stalled output beat changed.");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> char_ok)
    else $error("Output character outside the digit set.");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == itra_pkg::CH_MINUS |-> !out_tlast)
    else $error("Minus sign marked as the final character.");

  a_minus_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata == itra_pkg::CH_MINUS |=>
      !(out_tvalid && out_tdata == itra_pkg::CH_MINUS))
    else $error("Two minus signs in a row.");

endmodule

bind integer_to_radix_ascii itra_checker u_itra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

// ===== bench/integer_to_radix_ascii_tb.sv =====
module integer_to_radix_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W     = 32;
  localparam int IN_W        = ((VALUE_W + itra_pkg::RADIX_W + 7) / 8) * 8;
  localparam int TAIL_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_NUMS = 480;

  typedef struct packed {
    logic [itra_pkg::CHAR_W-1:0] char_code;
    logic                        last;
  } text_beat_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            in_tuser = 1'b0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [itra_pkg::CHAR_W-1:0] out_tdata;
  logic            out_tlast;

  text_beat_t expected_text[$];
  text_beat_t want;
  int errors = 0;
  int numbers_sent = 0;
  int silent_numbers = 0;
  int chars_checked = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int stall_left = 0;
  int stall_mode = 0;

  integer_to_radix_ascii #(
    .VALUE_BITS(VALUE_W),
    .MAX_DIGITS(32)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver switches between always ready, random, periodic and heavy stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= (cycle_count % 4) != 3;
      end
      default: begin
        out_tready <= $urandom_range(0, 7) == 0;
      end
    endcase
  end

  function automatic int push_expected_text(input logic sgn, input logic [VALUE_W-1:0] v,
                                            input logic [itra_pkg::RADIX_W-1:0] r);
    logic [itra_pkg::DIGIT_W-1:0] digits [0:VALUE_W-1];
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] q;
    logic               neg;
    text_beat_t         b;
    int                 n;
    if (sgn && r > itra_pkg::RADIX_MAX) begin
      return 0;
    end
    if (r < itra_pkg::RADIX_MIN || r > itra_pkg::RADIX_MAX) begin
      b.char_code = itra_pkg::CH_ZERO;
      b.last = 1'b1;
      expected_text.push_back(b);
      return 1;
    end
    neg = sgn && v[VALUE_W-1];
    mag = neg ? (~v + 1'b1) : v;
    if (mag == '0) begin
      b.char_code = itra_pkg::CH_ZERO;
      b.last = 1'b1;
      expected_text.push_back(b);
      return 1;
    end
    n = 0;
    q = mag;
    while (q != '0) begin
      digits[n] = itra_pkg::DIGIT_W'(q % r);
      q = q / r;
      n++;
    end
    if (neg) begin
      b.char_code = itra_pkg::CH_MINUS;
      b.last = 1'b0;
      expected_text.push_back(b);
    end
    for (int i = n - 1; i >= 0; i--) begin
      b.char_code = (digits[i] < 10) ?
                    itra_pkg::CH_ZERO + itra_pkg::CHAR_W'(digits[i]) :
                    itra_pkg::CH_A + itra_pkg::CHAR_W'(digits[i] - 10);
      b.last = (i == 0);
      expected_text.push_back(b);
    end
    return n + (neg ? 1 : 0);
  endfunction

  // Acceptance is decided at the falling edge, where every handshake signal is settled.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_text.size() == 0) begin
        $error("unexpected beat: char_code %h last %b", out_tdata, out_tlast);
        errors++;
      end else begin
        want = expected_text.pop_front();
        chars_checked++;
        if (out_tdata !== want.char_code) begin
          $error("char_code: expected %h, got %h", want.char_code, out_tdata);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  task automatic send_number(input logic sgn, input logic [VALUE_W-1:0] v,
                             input logic [itra_pkg::RADIX_W-1:0] r, output int n_chars);
    int gap;
    bit taken;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'({r, v});
    in_tuser <= sgn;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end
    n_chars = push_expected_text(sgn, v, r);
    if (n_chars == 0) begin
      silent_numbers++;
    end
    burst_left--;
    numbers_sent++;
  endtask

  task automatic wait_for_text;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic test_directed;
    int n;
    send_number(1'b0, 32'd0, 5'd10, n);
    send_number(1'b1, 32'd0, 5'd10, n);
    send_number(1'b0, 32'hFFFF_FFFF, 5'd2, n);
    send_number(1'b0, 32'hFFFF_FFFF, 5'd16, n);
    send_number(1'b0, 32'hFFFF_FFFF, 5'd3, n);
    send_number(1'b1, 32'h8000_0000, 5'd10, n);
    send_number(1'b1, 32'h8000_0000, 5'd2, n);
    send_number(1'b1, 32'h7FFF_FFFF, 5'd10, n);
    send_number(1'b1, 32'hFFFF_FFFF, 5'd16, n);
    send_number(1'b1, 32'hFFFF_FFFF, 5'd0, n);
    send_number(1'b0, 32'h1234_5678, 5'd0, n);
    send_number(1'b0, 32'hDEAD_BEEF, 5'd1, n);
    send_number(1'b1, 32'h8000_0001, 5'd1, n);
    send_number(1'b0, 32'd12345, 5'd17, n);
    send_number(1'b0, 32'd0, 5'd31, n);
    send_number(1'b1, 32'hFFFF_FFF0, 5'd31, n);
    send_number(1'b1, 32'd0, 5'd17, n);
    send_number(1'b0, 32'hABCD_EF01, 5'd16, n);
    send_number(1'b0, 32'd1, 5'd2, n);
    send_number(1'b0, 32'd80, 5'd9, n);
    send_number(1'b1, 32'hFFFF_FFFF, 5'd2, n);
    send_number(1'b0, 32'd15, 5'd16, n);
    send_number(1'b1, 32'd255, 5'd8, n);
    wait_for_text();
  endtask

  task automatic test_pause_between;
    int n;
    for (int i = 0; i < 6; i++) begin
      send_number(1'($urandom_range(0, 1)), $urandom,
                  itra_pkg::RADIX_W'($urandom_range(2, 16)), n);
      if (i % 2 == 1) begin
        wait_for_text();
      end
    end
    wait_for_text();
  endtask

  task automatic test_random;
    int n;
    int counted;
    logic sgn;
    logic [VALUE_W-1:0] v;
    logic [itra_pkg::RADIX_W-1:0] r;
    counted = 0;
    while (counted < RANDOM_NUMS) begin
      sgn = 1'($urandom_range(0, 1));
      r = ($urandom_range(0, 4) != 0) ? itra_pkg::RADIX_W'($urandom_range(2, 16)) :
                                        itra_pkg::RADIX_W'($urandom_range(0, 31));
      case ($urandom_range(0, 5))
        0: v = $urandom;
        1: v = $urandom >> $urandom_range(0, 31);
        2: v = $urandom_range(0, 40);
        3: begin
          case ($urandom_range(0, 5))
            0: v = 32'd0;
            1: v = 32'd1;
            2: v = 32'hFFFF_FFFF;
            3: v = 32'h8000_0000;
            4: v = 32'h7FFF_FFFF;
            default: v = 32'h8000_0001;
          endcase
        end
        4: v = -$urandom_range(1, 1000);
        default: v = ~($urandom >> $urandom_range(0, 31));
      endcase
      send_number(sgn, v, r, n);
      if (n > 0) begin
        counted++;
      end
      if ($urandom_range(0, 59) == 0) begin
        wait_for_text();
      end
    end
    wait_for_text();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pause_between();
    test_random();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_text.size() != 0) begin
      $error("characters still outstanding: expected 0, got %0d", expected_text.size());
      errors++;
    end
    $display("Converted %0d numbers in bases 0 to 31, signed and unsigned (%0d gave no text).",
             numbers_sent, silent_numbers);
    $display("Checked %0d characters under random input gaps and output stalls.", chars_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/itra_pkg.sv
rtl/itra_ram.sv
rtl/itra_front.sv
rtl/itra_back.sv
rtl/integer_to_radix_ascii.sv
rtl/itra_checker.sv
bench/integer_to_radix_ascii_tb.sv
